### rtl/bta_pkg.sv
// shared types and constants for the binary trie address allocator
package bta_pkg;

  localparam int unsigned MAX_HOST_BITS_DEF = 8;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned HB_W = 4;
  localparam int unsigned BIT_SEL_W = $clog2(ADDR_W);

  localparam logic [HB_W-1:0] HOST_BITS_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic full;
    logic exists;
  } node_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE = 6'b000010,
    S_DOWN = 6'b000100,
    S_UP = 6'b001000,
    S_FREE = 6'b010000,
    S_OUT = 6'b100000
  } state_e;

endpackage

### rtl/binary_trie_address_allocator.sv
// Host address allocator: binary tree of exists/full flags kept in one node memory.
// An input transfer on in_valid_i/in_stall_o carries mode_i (allocate or free) and address_i.
// Allocate walks down the tree from the top host bit, following the requested address and
// taking the sibling where the requested child is full, then walks back up marking full
// nodes. Free walks down checking the path, then clears the full bits leaf to root.
// Each transfer gives exactly one result transfer on out_valid_o/out_stall_i with status_o,
// granted_address_o and allocated_count_o.
// Each transfer makes one node memory access per tree level on the way down, then one per
// level on the way up for an allocate, or one per path node, root included, to clear a free;
// each step of the down and up walks waits on the previous level's registered read data.
// A full tree, an invalid free or a double free finishes early.
// The result sits in an output register; the next item is taken while it waits, and the
// block holds a finished result internally if the output register is still stalled.
// After reset a clearing pass writes every node to zero, with in_stall_o high; host_bits
// writes on cfg_we_i are taken at any time and host_bits resets to 8.
module binary_trie_address_allocator #(
  parameter int unsigned MAX_HOST_BITS = bta_pkg::MAX_HOST_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bta_pkg::HB_W-1:0]       cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [bta_pkg::ADDR_W-1:0]     address_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic [bta_pkg::ADDR_W-1:0]     granted_address_o,
  output logic [bta_pkg::COUNT_W-1:0]    allocated_count_o
);

  localparam int unsigned NW = MAX_HOST_BITS + 1;
  localparam int unsigned NODE_COUNT = 1 << NW;
  localparam int unsigned HW = $clog2(MAX_HOST_BITS + 1);

  bta_pkg::state_e state_q, state_d;
  logic [NW-1:0] clr_q, clr_d;
  logic [bta_pkg::HB_W-1:0] hb_q;
  logic [HW-1:0] h_eff;
  logic [HW-1:0] dep_q, dep_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [bta_pkg::ADDR_W-1:0] a_q, a_d;
  logic mode_q, mode_d;
  logic child_full_q, child_full_d;
  bta_pkg::status_e status_q, status_d;
  logic [bta_pkg::COUNT_W-1:0] count_q, count_d;

  logic out_valid_q, out_valid_d;
  logic out_load;
  bta_pkg::status_e out_status_q;
  logic [bta_pkg::ADDR_W-1:0] out_addr_q;
  logic [bta_pkg::COUNT_W-1:0] out_count_q;

  // node memory, two read ports and one write port
  bta_pkg::node_t node_mem [NODE_COUNT];
  logic [NW-1:0] ra_a, ra_b, wa;
  logic we;
  bta_pkg::node_t wd, rd_a_q, rd_b_q;

  logic [HW-1:0] lvl;
  logic [bta_pkg::BIT_SEL_W-1:0] lvl_sel;
  logic bit_req, last, req_full, both_full, flip, cb;
  bta_pkg::node_t req, oth, cf;
  logic [NW-1:0] child0, cidx, cidx0, parent;
  logic nf;

  always_comb begin
    if (hb_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(hb_q) > MAX_HOST_BITS) begin
      h_eff = HW'(MAX_HOST_BITS);
    end else begin
      h_eff = HW'(hb_q);
    end
  end

  assign lvl = HW'(h_eff - HW'(1) - dep_q);
  assign lvl_sel = bta_pkg::BIT_SEL_W'(lvl);
  assign bit_req = a_q[lvl_sel];
  assign last = (dep_q == HW'(h_eff - HW'(1)));
  assign req = bit_req ? rd_b_q : rd_a_q;
  assign oth = bit_req ? rd_a_q : rd_b_q;
  assign req_full = req.exists & req.full;
  assign both_full = rd_a_q.exists & rd_a_q.full & rd_b_q.exists & rd_b_q.full;
  assign flip = (mode_q == bta_pkg::MODE_ALLOC) & req_full;
  assign cb = bit_req ^ flip;
  assign cf = flip ? oth : req;
  assign child0 = NW'({idx_q, 1'b0});
  assign cidx = child0 | NW'(cb);
  assign cidx0 = NW'({cidx, 1'b0});
  assign parent = idx_q >> 1;
  // a node on the way up is full once it was, or once both children are full
  assign nf = rd_a_q.full | (child_full_q & rd_b_q.exists & rd_b_q.full);

  assign out_load = (state_q == bta_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    dep_d = dep_q;
    idx_d = idx_q;
    a_d = a_q;
    mode_d = mode_q;
    child_full_d = child_full_q;
    status_d = status_q;
    count_d = count_q;
    we = 1'b0;
    wa = idx_q;
    wd = '0;
    ra_a = NW'(2);
    ra_b = NW'(3);
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      bta_pkg::S_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        clr_d = clr_q + NW'(1);
        if (clr_q == '1) begin
          state_d = bta_pkg::S_IDLE;
        end
      end
      bta_pkg::S_IDLE: begin
        // root children are read here so the walk starts with data in hand
        if (in_valid_i) begin
          mode_d = mode_i;
          a_d = address_i;
          idx_d = NW'(1);
          dep_d = '0;
          state_d = bta_pkg::S_DOWN;
        end
      end
      bta_pkg::S_DOWN: begin
        if (mode_q == bta_pkg::MODE_ALLOC) begin
          if (dep_q == '0 && both_full) begin
            status_d = bta_pkg::ST_FULL;
            state_d = bta_pkg::S_OUT;
          end else begin
            if (flip) begin
              a_d = a_q ^ (bta_pkg::ADDR_W'(1) << lvl_sel);
            end
            we = 1'b1;
            wa = cidx;
            idx_d = cidx;
            if (last) begin
              wd.full = 1'b1;
              wd.exists = 1'b1;
              if (!cf.full && count_q != bta_pkg::COUNT_MAX) begin
                count_d = count_q + bta_pkg::COUNT_W'(1);
              end
              child_full_d = 1'b1;
              ra_a = idx_q;
              ra_b = cidx ^ NW'(1);
              state_d = bta_pkg::S_UP;
            end else begin
              wd.full = cf.full;
              wd.exists = 1'b1;
              dep_d = dep_q + HW'(1);
              ra_a = cidx0;
              ra_b = cidx0 | NW'(1);
            end
          end
        end else begin
          if (!req.exists) begin
            status_d = bta_pkg::ST_INVALID;
            state_d = bta_pkg::S_OUT;
          end else if (last) begin
            if (!req.full) begin
              status_d = bta_pkg::ST_DOUBLE;
              state_d = bta_pkg::S_OUT;
            end else begin
              idx_d = cidx;
              if (count_q != '0) begin
                count_d = count_q - bta_pkg::COUNT_W'(1);
              end
              state_d = bta_pkg::S_FREE;
            end
          end else begin
            idx_d = cidx;
            dep_d = dep_q + HW'(1);
            ra_a = cidx0;
            ra_b = cidx0 | NW'(1);
          end
        end
      end
      bta_pkg::S_UP: begin
        we = 1'b1;
        wa = parent;
        wd.full = nf;
        wd.exists = rd_a_q.exists;
        child_full_d = nf;
        idx_d = parent;
        ra_a = parent >> 1;
        ra_b = parent ^ NW'(1);
        if (parent == NW'(1)) begin
          status_d = bta_pkg::ST_OK;
          state_d = bta_pkg::S_OUT;
        end
      end
      bta_pkg::S_FREE: begin
        // every node below the root on a checked path exists; the root never has the bit
        we = 1'b1;
        wa = idx_q;
        wd.full = 1'b0;
        wd.exists = (idx_q != NW'(1));
        idx_d = parent;
        if (idx_q == NW'(1)) begin
          status_d = bta_pkg::ST_OK;
          state_d = bta_pkg::S_OUT;
        end
      end
      bta_pkg::S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d = bta_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bta_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      node_mem[wa] <= wd;
    end
    rd_a_q <= node_mem[ra_a];
    rd_b_q <= node_mem[ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::S_CLEAR;
      clr_q <= '0;
      hb_q <= bta_pkg::HOST_BITS_RESET;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (cfg_we_i) begin
        hb_q <= cfg_data_i;
      end
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dep_q <= dep_d;
    idx_q <= idx_d;
    a_q <= a_d;
    mode_q <= mode_d;
    child_full_q <= child_full_d;
    status_q <= status_d;
    if (out_load) begin
      out_status_q <= status_q;
      out_addr_q <= a_q;
      out_count_q <= count_q;
    end
  end

  assign in_stall_o = (state_q != bta_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign granted_address_o = out_addr_q;
  assign allocated_count_o = out_count_q;

  a_count_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bta_pkg::S_IDLE || state_q == bta_pkg::S_CLEAR) |=> $stable(count_q))
    else $error("allocated count changed with no item in flight");

  a_no_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q != bta_pkg::S_CLEAR) |-> (wa != '0))
    else $error("node memory write to unused node zero");

  a_free_check_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bta_pkg::S_DOWN && mode_q == bta_pkg::MODE_FREE) |-> !we)
    else $error("node memory written before free path was checked");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bta_pkg::S_OUT))
    else $error("result transfer raised outside the result state");

endmodule
